@@ hdl/isbn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbn_pkg
// Shared types, codes and constants of the ISBN digit validator and completer.
// ----------------------------------------------------------------------------
package isbn_pkg;

  localparam int NDIG         = 13;
  localparam int NUM_W        = 4 * NDIG;
  localparam int RESULT_LIMIT = 16;

  localparam logic [3:0] POS_CHK10  = 4'd9;
  localparam logic [3:0] POS_CHK13  = 4'd12;
  localparam logic [3:0] LEN10      = 4'd10;
  localparam logic [3:0] LEN13      = 4'd13;
  localparam logic [3:0] COUNT_MAX  = 4'd14;
  localparam logic [3:0] MIN_TYPED  = 4'd3;
  localparam logic [3:0] DIGIT_NINE = 4'd9;

  // Prefix digits that select ISBN-13.
  localparam logic [3:0] PFX_FIRST   = 4'd9;
  localparam logic [3:0] PFX_SECOND  = 4'd7;
  localparam logic [3:0] PFX_THIRD_A = 4'd8;
  localparam logic [3:0] PFX_THIRD_B = 4'd9;

  typedef logic [3:0] nib_t;
  typedef nib_t [NDIG-1:0] digs_t;

  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_CLEAR    = 2'd1,
    REQ_COMPLETE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CAND   = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    T_UNKNOWN = 2'd0,
    T_ISBN10  = 2'd1,
    T_ISBN13  = 2'd2,
    T_WRONG   = 2'd3
  } isbn_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_VWAIT,
    S_STAT,
    S_REQ,
    S_CSTART,
    S_CWAIT,
    S_CCAP,
    S_INC,
    S_OUT
  } isbn_state_t;

  typedef struct packed {
    logic start;
    logic mode13;
  } chk_ctrl_t;

  typedef struct packed {
    logic done;
    nib_t idx;
    nib_t value;
  } chk_stat_t;

  typedef struct packed {
    logic load;
    logic wr_chk;
    logic inc_start;
  } cand_ctrl_t;

  typedef struct packed {
    logic inc_done;
    logic wrapped;
  } cand_stat_t;

endpackage

@@ hdl/isbn_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbn_chk
// Digit-serial check value unit: one digit per cycle, mod-11 or mod-10 sum.
// ----------------------------------------------------------------------------
module isbn_chk import isbn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  chk_ctrl_t ctrl,
  input  nib_t      digit,
  output chk_stat_t stat
);

  localparam nib_t LAST10 = POS_CHK10 - 4'd1;
  localparam nib_t LAST13 = POS_CHK13 - 4'd1;

  // Remainders by reciprocal multiplication, exact for any 8-bit value.
  function automatic nib_t mod11_8(input logic [7:0] v);
    logic [17:0] p;
    logic [7:0]  r;
    p = 18'(v) * 18'd745;
    r = v - 8'(p[17:13]) * 8'd11;
    return r[3:0];
  endfunction

  function automatic nib_t mod10_8(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  r;
    p = 16'(v) * 16'd205;
    r = v - 8'(p[15:11]) * 8'd10;
    return r[3:0];
  endfunction

  logic       busy_r;
  logic       done_r;
  logic       mode_r;
  nib_t       idx_r;
  nib_t       acc_r;
  nib_t       weight;
  nib_t       last_idx;
  logic [7:0] sum;
  nib_t       acc_nxt;

  always_comb begin
    weight   = mode_r ? (idx_r[0] ? 4'd3 : 4'd1) : idx_r + 4'd1;
    last_idx = mode_r ? LAST13 : LAST10;
    sum      = {4'd0, acc_r} + {4'd0, digit} * {4'd0, weight};
    acc_nxt  = mode_r ? mod10_8(sum) : mod11_8(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= 1'b0;
      idx_r  <= '0;
      acc_r  <= '0;
    end else begin
      done_r <= !ctrl.start && busy_r && (idx_r == last_idx);
      if (ctrl.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        acc_r  <= '0;
        mode_r <= ctrl.mode13;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        idx_r <= idx_r + 4'd1;
        if (idx_r == last_idx) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    stat.done  = done_r;
    stat.idx   = idx_r;
    // ISBN-13 takes the tens complement of the weighted sum.
    stat.value = mode_r ? ((acc_r == 4'd0) ? 4'd0 : 4'd10 - acc_r) : acc_r;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !busy_r)
    else $error("check unit started while a pass is running");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("check done without a running pass");

endmodule

@@ hdl/isbn_cand.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbn_cand
// Candidate digit register with a digit-serial decimal incrementer.
// ----------------------------------------------------------------------------
module isbn_cand import isbn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cand_ctrl_t ctrl,
  input  nib_t       base,
  input  nib_t       chk_pos,
  input  nib_t       chk_val,
  input  digs_t      store,
  input  nib_t       rd_idx,
  output nib_t       rd_digit,
  output digs_t      digs,
  output cand_stat_t stat
);

  digs_t cand_r;
  logic  busy_r;
  logic  done_r;
  logic  wrap_r;
  nib_t  pos_r;
  nib_t  addr;
  nib_t  cur;

  // One read port, shared by the incrementer and the check unit.
  always_comb begin
    addr     = busy_r ? pos_r : rd_idx;
    cur      = cand_r[addr];
    rd_digit = cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      wrap_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      done_r <= !ctrl.inc_start && busy_r &&
                ((pos_r >= chk_pos) || (cur < DIGIT_NINE));
      if (ctrl.inc_start) begin
        busy_r <= 1'b1;
        pos_r  <= base;
      end else if (busy_r) begin
        if (pos_r >= chk_pos) begin
          // Carry ran past the last free digit: all candidates are done.
          busy_r <= 1'b0;
          wrap_r <= 1'b1;
        end else if (cur >= DIGIT_NINE) begin
          pos_r <= pos_r + 4'd1;
        end else begin
          busy_r <= 1'b0;
          wrap_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < NDIG; i++) begin
        cand_r[i] <= (4'(i) < base) ? store[i] : 4'd0;
      end
    end else if (ctrl.wr_chk) begin
      cand_r[chk_pos] <= chk_val;
    end else if (busy_r && (pos_r < chk_pos)) begin
      cand_r[pos_r] <= (cur >= DIGIT_NINE) ? 4'd0 : cur + 4'd1;
    end
  end

  assign digs          = cand_r;
  assign stat.inc_done = done_r;
  assign stat.wrapped  = wrap_r;

endmodule

@@ hdl/isbn_digit_validator_completer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbn_digit_validator_completer
// Stores ISBN digits, reports type and validity, and enumerates completions.
// ----------------------------------------------------------------------------
// Push or clear: the status item passes S_EVAL and S_STAT, and when the number is
// complete also S_VWAIT, where the digit-serial check pass takes one digit per
// cycle. A completion request on a valid number or one that cannot be completed
// gives a direct answer from S_REQ; otherwise each candidate takes a check pass,
// a capture and a carry walk, and a want_count of zero gives no item. One item at a time. Reset
// empties the number and the enumeration; digit stores are undefined until written.
module isbn_digit_validator_completer import isbn_pkg::*; #(
  parameter int MAX_COMPLETIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] digit, [11:4] want_count
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [1:0] isbn_type, [2] is_valid, [6:3] digit_count,
                                  // [58:7] number_digits, [62:59] number_length
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  localparam int RES_LIMIT = (MAX_COMPLETIONS < RESULT_LIMIT) ? MAX_COMPLETIONS
                                                              : RESULT_LIMIT;
  localparam int CNT_W = $clog2(RES_LIMIT + 1);
  localparam logic [7:0]       WANT_MAX = 8'(RES_LIMIT);
  localparam logic [CNT_W-1:0] N_MAX    = CNT_W'(RES_LIMIT);

  function automatic logic [NUM_W-1:0] pack_digs(input digs_t d, input nib_t n);
    logic [NUM_W-1:0] v;
    v = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (4'(i) < n) v[NUM_W-1-4*i -: 4] = d[i];
    end
    return v;
  endfunction

  isbn_state_t      state_r, state_nxt;
  digs_t            store_r;
  nib_t             count_r;
  logic             valid_r;
  logic             started_r;
  logic             src_cand_r;
  logic [7:0]       want_r;
  logic [CNT_W-1:0] rem_r;

  kind_t            okind_r;
  isbn_t            otype_r;
  logic             ovalid_r;
  nib_t             ocount_r;
  logic [NUM_W-1:0] odigits_r;
  nib_t             olen_r;
  logic             olast_r;

  isbn_t            type_w;
  logic             complete_w;
  logic             bad_w;
  nib_t             chk_pos_w;
  nib_t             full_len_w;
  nib_t             stat_n_w;
  logic [CNT_W-1:0] n_w;

  chk_ctrl_t        chk_ctrl;
  chk_stat_t        chk_stat;
  nib_t             chk_digit;
  cand_ctrl_t       cand_ctrl;
  cand_stat_t       cand_stat;
  nib_t             cand_rd;
  digs_t            cand_digs;

  logic             in_acc;

  assign in_acc = in_tvalid & in_tready;

  always_comb begin
    type_w = T_UNKNOWN;
    if (count_r >= MIN_TYPED) begin
      if (store_r[0] == PFX_FIRST && store_r[1] == PFX_SECOND &&
          (store_r[2] == PFX_THIRD_A || store_r[2] == PFX_THIRD_B)) begin
        type_w = (count_r <= LEN13) ? T_ISBN13 : T_WRONG;
      end else begin
        type_w = (count_r <= LEN10) ? T_ISBN10 : T_WRONG;
      end
    end
    complete_w = (type_w == T_ISBN10 && count_r == LEN10) ||
                 (type_w == T_ISBN13 && count_r == LEN13);
    chk_pos_w  = (type_w == T_ISBN13) ? POS_CHK13 : POS_CHK10;
    full_len_w = complete_w ? count_r : 4'd0;
    stat_n_w   = (count_r > LEN13) ? LEN13 : count_r;
    bad_w      = (type_w == T_UNKNOWN) || (type_w == T_WRONG) || (count_r > chk_pos_w);
    n_w        = (want_r > WANT_MAX) ? N_MAX : want_r[CNT_W-1:0];
    chk_digit  = src_cand_r ? cand_rd : store_r[chk_stat.idx];
  end

  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    out_tvalid       = 1'b0;
    chk_ctrl.start   = 1'b0;
    chk_ctrl.mode13  = (type_w == T_ISBN13);
    cand_ctrl        = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (req_t'(in_tuser))
            REQ_PUSH:     state_nxt = S_EVAL;
            REQ_CLEAR:    state_nxt = S_EVAL;
            REQ_COMPLETE: state_nxt = S_REQ;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_EVAL: begin
        if (complete_w) begin
          chk_ctrl.start = 1'b1;
          state_nxt      = S_VWAIT;
        end else begin
          state_nxt = S_STAT;
        end
      end
      S_VWAIT: begin
        if (chk_stat.done) state_nxt = S_STAT;
      end
      S_STAT: state_nxt = S_OUT;
      S_REQ: begin
        if (valid_r || bad_w) begin
          state_nxt = S_OUT;
        end else if (n_w == '0) begin
          state_nxt = S_IDLE;
        end else begin
          cand_ctrl.load = !started_r;
          state_nxt      = S_CSTART;
        end
      end
      S_CSTART: begin
        chk_ctrl.start = 1'b1;
        state_nxt      = S_CWAIT;
      end
      S_CWAIT: begin
        if (chk_stat.done) begin
          cand_ctrl.wr_chk = 1'b1;
          state_nxt        = S_CCAP;
        end
      end
      S_CCAP: begin
        cand_ctrl.inc_start = 1'b1;
        state_nxt           = S_INC;
      end
      S_INC: begin
        if (cand_stat.inc_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = olast_r ? S_IDLE : S_CSTART;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      valid_r    <= 1'b0;
      started_r  <= 1'b0;
      src_cand_r <= 1'b0;
      rem_r      <= '0;
      olast_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (req_t'(in_tuser))
              REQ_PUSH: begin
                if (count_r < COUNT_MAX) count_r <= count_r + 4'd1;
                valid_r   <= 1'b0;
                started_r <= 1'b0;
              end
              REQ_CLEAR: begin
                count_r   <= '0;
                valid_r   <= 1'b0;
                started_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_EVAL: src_cand_r <= 1'b0;
        S_VWAIT: begin
          if (chk_stat.done) valid_r <= (chk_stat.value == store_r[chk_pos_w]);
        end
        S_STAT: olast_r <= 1'b1;
        S_REQ: begin
          if (valid_r || bad_w) begin
            olast_r <= 1'b1;
          end else if (n_w != '0) begin
            rem_r     <= n_w;
            started_r <= 1'b1;
          end
        end
        S_CSTART: src_cand_r <= 1'b1;
        S_CCAP: rem_r <= rem_r - CNT_W'(1);
        S_INC: begin
          if (cand_stat.inc_done) olast_r <= cand_stat.wrapped || (rem_r == '0);
        end
        default: ;
      endcase
    end
  end

  // Digit store and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc && req_t'(in_tuser) == REQ_PUSH && count_r < LEN13) begin
      store_r[count_r] <= in_tdata[3:0];
    end
    if (state_r == S_STAT || state_r == S_REQ || state_r == S_CCAP) begin
      otype_r  <= type_w;
      ovalid_r <= valid_r;
      ocount_r <= count_r;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) want_r <= in_tdata[11:4];
      end
      S_STAT: begin
        okind_r   <= KIND_STATUS;
        odigits_r <= pack_digs(store_r, stat_n_w);
        olen_r    <= full_len_w;
      end
      S_REQ: begin
        if (valid_r) begin
          okind_r   <= KIND_CAND;
          odigits_r <= pack_digs(store_r, count_r);
          olen_r    <= count_r;
        end else begin
          okind_r   <= KIND_NONE;
          odigits_r <= '0;
          olen_r    <= '0;
        end
      end
      S_CCAP: begin
        okind_r   <= KIND_CAND;
        odigits_r <= pack_digs(cand_digs, chk_pos_w + 4'd1);
        olen_r    <= chk_pos_w + 4'd1;
      end
      default: ;
    endcase
  end

  isbn_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (chk_ctrl),
    .digit (chk_digit),
    .stat  (chk_stat)
  );

  isbn_cand u_cand (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (cand_ctrl),
    .base     (count_r),
    .chk_pos  (chk_pos_w),
    .chk_val  (chk_stat.value),
    .store    (store_r),
    .rd_idx   (chk_stat.idx),
    .rd_digit (cand_rd),
    .digs     (cand_digs),
    .stat     (cand_stat)
  );

  assign out_tdata = {1'b0, olen_r, odigits_r, ocount_r, ovalid_r, otype_r};
  assign out_tuser = okind_r;
  assign out_tlast = olast_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result item is pending");

  a_valid_typed: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (type_w == T_ISBN10 || type_w == T_ISBN13))
    else $error("valid flag set for an untyped number");

  a_cand_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_CAND) |-> (olen_r == LEN10 || olen_r == LEN13))
    else $error("candidate item without a full length");

  a_rem_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CCAP) |-> (rem_r != '0))
    else $error("candidate produced beyond the wanted count");

endmodule
